// ===== sv/cpsl_pkg.sv =====
// Package for the cascaded position / speed loop unit.
// Holds field widths, register indexes, reset values, loop constants, the
// controller state and command types, and the fixed-point rounding helper.
package cpsl_pkg;

	localparam int TARGET_W = 25;
	localparam int COUNT_W  = 16;
	localparam int MEAS_W   = 32;
	localparam int DUTY_W   = 16;
	localparam int PERIOD_W = 15;
	localparam int GAIN_W   = 16;
	localparam int CMD_W    = 20;
	localparam int OPA_W    = 35;
	localparam int MULB_W   = GAIN_W + 1;
	localparam int PROD_W   = OPA_W + MULB_W;
	localparam int RND_W    = PROD_W - 16;
	localparam int SUM_W    = RND_W;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_DECAY = 3'd5;

	localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD    = 15'd1000;
	localparam logic [GAIN_W-1:0]   RST_SPEED_SCALE   = 16'd802;
	localparam logic [GAIN_W-1:0]   RST_ANGLE_SCALE   = 16'd481;
	localparam logic [GAIN_W-1:0]   RST_POSITION_GAIN = 16'd18350;
	localparam logic [GAIN_W-1:0]   RST_SPEED_GAIN    = 16'd2621;
	localparam logic [GAIN_W-1:0]   RST_COMMAND_DECAY = 16'd52429;

	localparam int CMD_CLAMP_LIMIT = 32768;
	localparam int CMD_CLAMP_VALUE = 26214;
	localparam int CMD_DEADZONE    = 2294;

	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_period;
		logic [GAIN_W-1:0]   speed_scale;
		logic [GAIN_W-1:0]   angle_scale;
		logic [GAIN_W-1:0]   position_gain;
		logic [GAIN_W-1:0]   speed_gain;
		logic [GAIN_W-1:0]   command_decay;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPEED,
		ST_ANGLE,
		ST_PERR,
		ST_PGAIN,
		ST_SERR,
		ST_SGAIN,
		ST_DECAY,
		ST_CLAMP,
		ST_DUTY,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SPEED,
		OP_ANGLE,
		OP_PERR,
		OP_PGAIN,
		OP_SERR,
		OP_SGAIN,
		OP_DECAY,
		OP_CLAMP,
		OP_DUTY
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	// Q16.16 times Q0.16 back to Q16.16, round to nearest, ties up
	function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(32768);
		return RND_W'(t >>> 16);
	endfunction

endpackage

// ===== sv/cpsl_regs.sv =====
// Configuration register file of the cascaded position / speed loop unit.
// Depends on cpsl_pkg for register indexes, widths and reset values.
module cpsl_regs
	import cpsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period    <= RST_PWM_PERIOD;
			cfg_q.speed_scale   <= RST_SPEED_SCALE;
			cfg_q.angle_scale   <= RST_ANGLE_SCALE;
			cfg_q.position_gain <= RST_POSITION_GAIN;
			cfg_q.speed_gain    <= RST_SPEED_GAIN;
			cfg_q.command_decay <= RST_COMMAND_DECAY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PWM_PERIOD:    cfg_q.pwm_period    <= cfg_data[PERIOD_W-1:0];
				REG_SPEED_SCALE:   cfg_q.speed_scale   <= cfg_data;
				REG_ANGLE_SCALE:   cfg_q.angle_scale   <= cfg_data;
				REG_POSITION_GAIN: cfg_q.position_gain <= cfg_data;
				REG_SPEED_GAIN:    cfg_q.speed_gain    <= cfg_data;
				REG_COMMAND_DECAY: cfg_q.command_decay <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/cpsl_ctrl.sv =====
// Controller state machine of the cascaded position / speed loop unit.
// Sequences the shared multiplier steps; depends on cpsl_pkg for types.
module cpsl_ctrl
	import cpsl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser) state_d = ST_SPEED;
			end
			ST_SPEED: state_d = ST_ANGLE;
			ST_ANGLE: state_d = ST_PERR;
			ST_PERR:  state_d = ST_PGAIN;
			ST_PGAIN: state_d = ST_SERR;
			ST_SERR:  state_d = ST_SGAIN;
			ST_SGAIN: state_d = ST_DECAY;
			ST_DECAY: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_DUTY;
			ST_DUTY:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ctl.load = 1'b0;
		ctl.op   = OP_NONE;
		ctl.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid && s_tuser;
			end
			ST_SPEED: ctl.op = OP_SPEED;
			ST_ANGLE: ctl.op = OP_ANGLE;
			ST_PERR:  ctl.op = OP_PERR;
			ST_PGAIN: ctl.op = OP_PGAIN;
			ST_SERR:  ctl.op = OP_SERR;
			ST_SGAIN: ctl.op = OP_SGAIN;
			ST_DECAY: ctl.op = OP_DECAY;
			ST_CLAMP: ctl.op = OP_CLAMP;
			ST_DUTY:  ctl.op = OP_DUTY;
			ST_EMIT:  ctl.emit = sts.out_free;
			default: begin
			end
		endcase
	end

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> (state_q == ST_SPEED))
		else $error("accepted sample did not start the sequence");

	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> (state_q == ST_IDLE))
		else $error("item without sample left idle");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !sts.out_free) |=> (state_q == ST_EMIT))
		else $error("result dropped while output busy");

endmodule

// ===== sv/cpsl_dp.sv =====
// Datapath of the cascaded position / speed loop unit: operand registers,
// one shared signed multiplier, command state and output register.
// Depends on cpsl_pkg for widths, constants and the rounding helper.
module cpsl_dp
	import cpsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  ctl_t                  ctl,
	output sts_t                  sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic signed [TARGET_W-1:0] target_q;
	logic signed [COUNT_W-1:0]  vel_q;
	logic signed [COUNT_W-1:0]  pos_q;
	logic signed [MEAS_W-1:0]   speed_q;
	logic signed [MEAS_W-1:0]   angle_q;
	logic signed [OPA_W-1:0]    opa_q;
	logic signed [OPA_W-1:0]    term_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [CMD_W-1:0]    cmd_q;
	logic                       m_valid_q;
	logic [OUT_DATA_W-1:0]      m_data_q;

	logic signed [OPA_W-1:0]    mul_a;
	logic signed [MULB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   prod_d;
	logic signed [RND_W-1:0]    prod_rnd;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    clamped;
	logic signed [SUM_W-1:0]    cmd_next;
	logic signed [PROD_W-1:0]   duty_sum;
	logic [DUTY_W-1:0]          duty;

	assign sts.out_free = !m_valid_q || m_tready;
	assign m_tvalid     = m_valid_q;
	assign m_tdata      = m_data_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.op)
			OP_SPEED: begin
				mul_a = OPA_W'(vel_q);
				mul_b = $signed({1'b0, cfg.speed_scale});
			end
			OP_ANGLE: begin
				mul_a = OPA_W'(pos_q);
				mul_b = $signed({1'b0, cfg.angle_scale});
			end
			OP_PGAIN: begin
				mul_a = opa_q;
				mul_b = $signed({1'b0, cfg.position_gain});
			end
			OP_SGAIN: begin
				mul_a = opa_q;
				mul_b = $signed({1'b0, cfg.speed_gain});
			end
			OP_DECAY: begin
				mul_a = OPA_W'(cmd_q);
				mul_b = $signed({1'b0, cfg.command_decay});
			end
			OP_DUTY: begin
				mul_a = OPA_W'(cmd_q);
				mul_b = $signed({2'b00, cfg.pwm_period});
			end
			default: begin
			end
		endcase
	end

	assign prod_d   = mul_a * mul_b;
	assign prod_rnd = rnd_q16(prod_q);
	assign sum      = SUM_W'(term_q) + prod_rnd;

	always_comb begin
		if (sum > SUM_W'(CMD_CLAMP_LIMIT)) begin
			clamped = SUM_W'(CMD_CLAMP_VALUE);
		end else if (sum < -SUM_W'(CMD_CLAMP_LIMIT)) begin
			clamped = -SUM_W'(CMD_CLAMP_VALUE);
		end else begin
			clamped = sum;
		end
		if (clamped < SUM_W'(CMD_DEADZONE) && clamped > -SUM_W'(CMD_DEADZONE)) begin
			cmd_next = '0;
		end else begin
			cmd_next = clamped;
		end
	end

	assign duty_sum = prod_q + $signed({{(PROD_W-PERIOD_W-15){1'b0}},
		cfg.pwm_period[PERIOD_W-1:1], 16'h0000});
	assign duty     = duty_sum[PROD_W-1] ? '0 : duty_sum[DUTY_W+15:16];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			target_q <= $signed(s_tdata[TARGET_W-1:0]);
			vel_q    <= $signed(s_tdata[TARGET_W+COUNT_W-1:TARGET_W]);
			pos_q    <= $signed(s_tdata[TARGET_W+2*COUNT_W-1:TARGET_W+COUNT_W]);
		end
		if (ctl.op != OP_NONE) prod_q <= prod_d;
		unique case (ctl.op)
			OP_ANGLE: speed_q <= $signed(prod_q[MEAS_W-1:0]);
			OP_PERR: begin
				angle_q <= $signed(prod_q[MEAS_W-1:0]);
				opa_q   <= OPA_W'(target_q) - OPA_W'($signed(prod_q[MEAS_W-1:0]));
			end
			OP_SERR:  opa_q  <= OPA_W'(prod_rnd) - OPA_W'(speed_q);
			OP_DECAY: term_q <= OPA_W'(prod_rnd);
			default: begin
			end
		endcase
		if (ctl.emit) m_data_q <= {angle_q, speed_q, duty};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_CLAMP) cmd_q <= CMD_W'(cmd_next);
			if (ctl.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q <= CMD_W'(CMD_CLAMP_LIMIT)) && (cmd_q >= -CMD_W'(CMD_CLAMP_LIMIT)))
		else $error("drive command out of clamp range");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op != OP_CLAMP) |=> $stable(cmd_q))
		else $error("drive command changed outside clamp step");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!m_valid_q || m_tready))
		else $error("output register overwritten");

endmodule

// ===== sv/cascaded_position_speed_loop_unit.sv =====
// Top level of the cascaded position / speed loop unit.
// Instantiates cpsl_regs, cpsl_ctrl and cpsl_dp; depends on cpsl_pkg.
//
// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        s_tdata[56:0], s_tuser = new_sample
// m_       out  m_tvalid / m_tready        m_tdata[79:0]
// cfg_     in   cfg_valid / cfg_ready      cfg_index[2:0], cfg_data[15:0]
//
// A sample item steps through the controller states to a loaded output
// register, with six passes through the one shared 35x17 multiplier plus add
// steps; the next item is taken only after the load. An item with new_sample
// low is taken in IDLE and gives no result. Reset clears the drive command and
// loads the register defaults. A stalled output holds the last step until the
// output register frees up; the next item is taken while a result still waits.
module cascaded_position_speed_loop_unit
	import cpsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// target_angle[24:0], velocity_count[40:25], position_count[56:41]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// new_sample[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// duty[15:0], rotor_speed[47:16], measured_angle[79:48]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	cpsl_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.ctl      (ctl)
	);

	cpsl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ctl      (ctl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
